@@ sv/stable_sorted_priority_queue_defines.svh @@
// Assertion helpers shared by the queue RTL
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define SSPQ_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication
`define SSPQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SSPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sspq_pkg.sv @@
package sspq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned ENTRY_W  = KEY_W + TAG_W;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Request field widths on the ports
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned INKEY_W  = 16;
  localparam int unsigned INTAG_W  = 16;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned S_DATA_W = 40;

  // Result field widths on the ports
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned OKEY_W   = 16;
  localparam int unsigned OTAG_W   = 16;
  localparam int unsigned RCNT_W   = 7;
  localparam int unsigned OCNT_W   = 7;
  localparam int unsigned M_DATA_W = 88;

  typedef enum logic [KIND_W-1:0] {
    KIND_OFFER  = 3'd0,
    KIND_POLL   = 3'd1,
    KIND_READ   = 3'd2,
    KIND_REMTAG = 3'd3,
    KIND_REMAT  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFF_RD,
    ST_OFF_CHK,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_INS_WR,
    ST_AT_RD,
    ST_AT_CHK,
    ST_RM_RD,
    ST_RM_WR,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_DONE
  } state_e;

  // True when key a must stand strictly ahead of key b
  function automatic logic ranks_ahead(input logic desc, input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b);
    ranks_ahead = desc ? (a > b) : (a < b);
  endfunction

endpackage

@@ sv/stable_sorted_priority_queue.sv @@
// Channel   Dir  Ports                        Contents
// request   in   s_axis_t{valid,ready,data,user}  kind in tuser; key, tag, index in tdata
// result    out  m_axis_t{valid,ready,data,user}  status in tuser; other fields in tdata
// config    in   cfg_wr_en_i, cfg_wr_data_i        order_descending
//
// Entries live in one RAM with a registered read; every step over an entry is
// a read, then a check or a write back. An offer scans from the head for its
// slot and shifts the tail up; poll and remove-at pull later entries down;
// read-at fetches one entry; remove-by-tag compacts the whole queue; full,
// empty, out-of-range and spare kinds go straight to the result.
// A result waits in the output register while the next request is already
// accepted; that request stalls in its last cycle until the register is free.
// Reset clears the count, order and handshake state; the RAM contents stay
// undefined and are never read beyond the count.
`include "stable_sorted_priority_queue_defines.svh"

module stable_sorted_priority_queue
  import sspq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic                cfg_wr_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] key, [31:16] tag, [37:32] index, [39:38] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // [2:0] kind
  input  logic [KIND_W-1:0]   s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [5:0] position, [21:6] out_key, [37:22] out_tag, [44:38] removed_count,
  // [51:45] count, [52] head_valid, [68:53] head_key, [84:69] head_tag, [87:85] zero
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [STATUS_W-1:0] m_axis_tuser
);

  state_e              state_q, state_d;
  logic                order_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]    wr_q, wr_d;
  logic [CNT_W-1:0]    removed_q, removed_d;
  kind_e               kind_q, kind_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [TAG_W-1:0]    tag_q, tag_d;
  status_e             status_q, status_d;
  logic [KEY_W-1:0]    okey_q, okey_d;
  logic [TAG_W-1:0]    otag_q, otag_d;
  logic [KEY_W-1:0]    head_key_q;
  logic [TAG_W-1:0]    head_tag_q;
  logic                m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0] m_data_q, m_data_d;
  logic [STATUS_W-1:0] m_user_q, m_user_d;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [TAG_W-1:0]    rd_tag;
  logic                s_fire;
  logic [CNT_W-1:0]    at_in;
  logic                head_valid;

  sspq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key        = ram_rdata[KEY_W-1:0];
  assign rd_tag        = ram_rdata[KEY_W +: TAG_W];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign head_valid    = (count_q != '0);
  assign at_in         = (kind_e'(s_axis_tuser) == KIND_POLL) ? '0
                       : CNT_W'(s_axis_tdata[32 +: INDEX_W]);

  // Sequence one request over the RAM; reads and writes of one step never
  // hit the same address in the same cycle
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    wr_d      = wr_q;
    removed_d = removed_q;
    kind_d    = kind_q;
    key_d     = key_q;
    tag_d     = tag_q;
    status_d  = status_q;
    okey_d    = okey_q;
    otag_d    = otag_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          kind_d    = kind_e'(s_axis_tuser);
          key_d     = s_axis_tdata[KEY_W-1:0];
          tag_d     = s_axis_tdata[INKEY_W +: TAG_W];
          status_d  = STAT_OK;
          okey_d    = '0;
          otag_d    = '0;
          removed_d = '0;
          ptr_d     = '0;
          wr_d      = '0;
          unique case (kind_e'(s_axis_tuser))
            KIND_OFFER: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                status_d = STAT_FULL;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_OFF_RD;
              end
            end
            KIND_POLL, KIND_READ, KIND_REMAT: begin
              ptr_d = at_in;
              if (at_in >= count_q) begin
                status_d = STAT_EMPTY;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_AT_RD;
              end
            end
            KIND_REMTAG: state_d = ST_CMP_RD;
            default:     state_d = ST_DONE;
          endcase
        end
      end

      // Scan forward for the first entry the new key ranks ahead of
      ST_OFF_RD: begin
        if (ptr_q == count_q) begin
          wr_d    = count_q;
          state_d = ST_SHF_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[ADDR_W-1:0];
          state_d   = ST_OFF_CHK;
        end
      end
      ST_OFF_CHK: begin
        if (ranks_ahead(order_q, key_q, rd_key)) begin
          wr_d    = count_q;
          state_d = ST_SHF_RD;
        end else begin
          ptr_d   = ptr_q + CNT_W'(1);
          state_d = ST_OFF_RD;
        end
      end

      // Move the tail up by one, from the back down to the insert point
      ST_SHF_RD: begin
        if (wr_q == ptr_q) begin
          state_d = ST_INS_WR;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(wr_q - CNT_W'(1));
          state_d   = ST_SHF_WR;
        end
      end
      ST_SHF_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wr_q[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        wr_d      = wr_q - CNT_W'(1);
        state_d   = ST_SHF_RD;
      end
      ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[ADDR_W-1:0];
        ram_wdata = {tag_q, key_q};
        count_d   = count_q + CNT_W'(1);
        state_d   = ST_DONE;
      end

      // Fetch the addressed entry for poll, read-at and remove-at
      ST_AT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q[ADDR_W-1:0];
        state_d   = ST_AT_CHK;
      end
      ST_AT_CHK: begin
        okey_d  = rd_key;
        otag_d  = rd_tag;
        state_d = (kind_q == KIND_READ) ? ST_DONE : ST_RM_RD;
      end

      // Close the gap: pull each later entry down by one
      ST_RM_RD: begin
        if (ptr_q + CNT_W'(1) >= count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(ptr_q + CNT_W'(1));
          state_d   = ST_RM_WR;
        end
      end
      ST_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ptr_d     = ptr_q + CNT_W'(1);
        state_d   = ST_RM_RD;
      end

      // Compact the queue, dropping every entry whose tag matches
      ST_CMP_RD: begin
        if (ptr_q == count_q) begin
          count_d = wr_q;
          state_d = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[ADDR_W-1:0];
          state_d   = ST_CMP_CHK;
        end
      end
      ST_CMP_CHK: begin
        if (rd_tag == tag_q) begin
          removed_d = removed_q + CNT_W'(1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = wr_q[ADDR_W-1:0];
          ram_wdata = ram_rdata;
          wr_d      = wr_q + CNT_W'(1);
        end
        ptr_d   = ptr_q + CNT_W'(1);
        state_d = ST_CMP_RD;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = status_q;
          m_data_d  = '0;
          if (kind_q == KIND_OFFER && status_q == STAT_OK) begin
            m_data_d[5:0] = POS_W'(ptr_q);
          end
          m_data_d[21:6]  = okey_q;
          m_data_d[37:22] = otag_q;
          m_data_d[44:38] = RCNT_W'(removed_q);
          m_data_d[51:45] = OCNT_W'(count_q);
          m_data_d[52]    = head_valid;
          m_data_d[68:53] = head_valid ? head_key_q : '0;
          m_data_d[84:69] = head_valid ? head_tag_q : '0;
          state_d         = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      order_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_wr_en_i) begin
        order_q <= cfg_wr_data_i;
      end
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    wr_q      <= wr_d;
    removed_q <= removed_d;
    kind_q    <= kind_d;
    key_q     <= key_d;
    tag_q     <= tag_d;
    status_q  <= status_d;
    okey_q    <= okey_d;
    otag_q    <= otag_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
    // Shadow the head entry on every write to the front slot
    if (ram_we && ram_waddr == '0) begin
      head_key_q <= ram_wdata[KEY_W-1:0];
      head_tag_q <= ram_wdata[KEY_W +: TAG_W];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `SSPQ_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `SSPQ_ASSERT_IMPL(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
                    "RAM read and write to the same entry")
  `SSPQ_ASSERT_NEXT(a_busy_after_req, s_fire, state_q != ST_IDLE,
                    "request accepted but sequencer stayed idle")
  `SSPQ_ASSERT_IMPL(a_ram_in_range, ram_we, {1'b0, ram_waddr} <= count_q,
                    "RAM write beyond the held entries")

endmodule

@@ sv/sspq_ram.sv @@
module sspq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/sspq_checker.sv @@
`timescale 1ns / 100ps

module sspq_checker
  import sspq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic                cfg_wr_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // [15:0] key, [31:16] tag, [37:32] index, [39:38] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // [2:0] kind
  input  logic [KIND_W-1:0]   s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [5:0] position, [21:6] out_key, [37:22] out_tag, [44:38] removed_count,
  // [51:45] count, [52] head_valid, [68:53] head_key, [84:69] head_tag, [87:85] zero
  input  logic [M_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  input  logic [STATUS_W-1:0] m_axis_tuser,
  output int unsigned         err_count_o,
  output int unsigned         awaited_o,
  output int unsigned         held_o
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [OKEY_W-1:0]   out_key;
    logic [OTAG_W-1:0]   out_tag;
    logic [RCNT_W-1:0]   removed;
    logic [OCNT_W-1:0]   count;
    logic                head_valid;
    logic [KEY_W-1:0]    head_key;
    logic [TAG_W-1:0]    head_tag;
  } queue_result_t;

  // Shadow of the sorted entries, the fill level and the order bit
  logic [KEY_W-1:0] slot_key [CAPACITY];
  logic [TAG_W-1:0] slot_tag [CAPACITY];
  int               fill;
  logic             descending;
  queue_result_t    awaited_results [$];
  int unsigned      mismatches = 0;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Apply one request to the shadow queue and return the result it must give
  function automatic queue_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [TAG_W-1:0] tag,
                                                  input logic [INDEX_W-1:0] idx);
    queue_result_t r;
    int            p;
    int            at;
    int            kept;
    int            i;
    r = '0;
    case (kind)
      KIND_OFFER: begin
        if (fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          // land behind every entry that does not rank strictly behind the new key
          p = 0;
          while (p < fill && !(descending ? (key > slot_key[p]) : (key < slot_key[p])))
            p++;
          for (i = fill; i > p; i--) begin
            slot_key[i] = slot_key[i-1];
            slot_tag[i] = slot_tag[i-1];
          end
          slot_key[p] = key;
          slot_tag[p] = tag;
          fill++;
          r.position = p[POS_W-1:0];
        end
      end
      KIND_POLL, KIND_READ, KIND_REMAT: begin
        at = (kind == KIND_POLL) ? 0 : int'(idx);
        if (at >= fill) begin
          r.status = STAT_EMPTY;
        end else begin
          r.out_key = slot_key[at];
          r.out_tag = slot_tag[at];
          if (kind != KIND_READ) begin
            for (i = at; i + 1 < fill; i++) begin
              slot_key[i] = slot_key[i+1];
              slot_tag[i] = slot_tag[i+1];
            end
            fill--;
          end
        end
      end
      KIND_REMTAG: begin
        // compact the survivors toward the head
        kept = 0;
        for (i = 0; i < fill; i++) begin
          if (slot_tag[i] == tag) begin
            r.removed++;
          end else begin
            slot_key[kept] = slot_key[i];
            slot_tag[kept] = slot_tag[i];
            kept++;
          end
        end
        fill = kept;
      end
      default: begin
      end
    endcase
    r.count = fill[OCNT_W-1:0];
    if (fill > 0) begin
      r.head_valid = 1'b1;
      r.head_key   = slot_key[0];
      r.head_tag   = slot_tag[0];
    end
    return r;
  endfunction

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst_ni) begin
      fill        = 0;
      descending  = 1'b0;
      awaited_results.delete();
      err_count_o <= 0;
      awaited_o   <= 0;
      held_o      <= 0;
    end else begin
      if (cfg_wr_en_i)
        descending = cfg_wr_data_i;
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(apply_request(s_axis_tuser, s_axis_tdata[15:0],
                                                s_axis_tdata[31:16], s_axis_tdata[37:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = m_axis_tuser;
        got.position   = m_axis_tdata[5:0];
        got.out_key    = m_axis_tdata[21:6];
        got.out_tag    = m_axis_tdata[37:22];
        got.removed    = m_axis_tdata[44:38];
        got.count      = m_axis_tdata[51:45];
        got.head_valid = m_axis_tdata[52];
        got.head_key   = m_axis_tdata[68:53];
        got.head_tag   = m_axis_tdata[84:69];
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request pending", got.status, 0);
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.position !== want.position)
            report_mismatch("position", got.position, want.position);
          if (got.out_key !== want.out_key)
            report_mismatch("out_key", got.out_key, want.out_key);
          if (got.out_tag !== want.out_tag)
            report_mismatch("out_tag", got.out_tag, want.out_tag);
          if (got.removed !== want.removed)
            report_mismatch("removed_count", got.removed, want.removed);
          if (got.count !== want.count)
            report_mismatch("count", got.count, want.count);
          if (got.head_valid !== want.head_valid)
            report_mismatch("head_valid", got.head_valid, want.head_valid);
          if (got.head_key !== want.head_key)
            report_mismatch("head_key", got.head_key, want.head_key);
          if (got.head_tag !== want.head_tag)
            report_mismatch("head_tag", got.head_tag, want.head_tag);
        end
      end
      awaited_o   <= awaited_results.size();
      held_o      <= fill;
      err_count_o <= mismatches;
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import sspq_pkg::*;

  // Kinds the block must ignore
  localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned PHASES       = 16;
  localparam int unsigned PHASE_ITEMS  = 105;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned POOL_SIZE    = 8;
  localparam int unsigned MAX_SEND_GAP = 12;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_wr_en_i   = 1'b0;
  logic                cfg_wr_data_i = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [KIND_W-1:0]   s_axis_tuser  = KIND_OFFER;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  int unsigned errors;
  int unsigned results_pending;
  int unsigned queue_fill;
  int unsigned cycles         = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_seq       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  stable_sorted_priority_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  sspq_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .err_count_o   (errors),
    .awaited_o     (results_pending),
    .held_o        (queue_fill)
  );

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [15:0] key,
                              input logic [15:0] tag, input logic [5:0] idx);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, idx, tag, key};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait for every pending result
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  task automatic write_order(input logic descending);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= descending;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  // Random request: equal keys and shared tags are common on purpose
  task automatic send_random(input int unsigned offer_pct);
    logic [KIND_W-1:0] kind;
    logic [15:0]       key;
    logic [15:0]       tag;
    logic [5:0]        idx;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < offer_pct) begin
      kind = KIND_OFFER;
    end else begin
      pick = $urandom_range(99);
      if (pick < 25)      kind = KIND_POLL;
      else if (pick < 50) kind = KIND_READ;
      else if (pick < 72) kind = KIND_REMTAG;
      else if (pick < 95) kind = KIND_REMAT;
      else                kind = KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
    end
    pick = $urandom_range(9);
    if (pick < 4)      key = 16'($urandom_range(POOL_SIZE - 1));
    else if (pick < 5) key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    else               key = 16'($urandom);
    tag = $urandom_range(1) ? 16'($urandom_range(POOL_SIZE - 1)) : 16'($urandom);
    idx = ($urandom_range(9) < 8) ? 6'($urandom_range(queue_fill)) : 6'($urandom_range(63));
    send_request(kind, key, tag, idx);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned offer_pct;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: poll, read and remove-at report empty, remove-by-tag removes nothing, spare kinds do nothing
    send_request(KIND_POLL,      16'h0000, 16'h0000, 6'd0);
    send_request(KIND_READ,      16'h0000, 16'h0000, 6'd0);
    send_request(KIND_REMAT,     16'h0000, 16'h0000, 6'd63);
    send_request(KIND_REMTAG,    16'h0000, 16'h1234, 6'd0);
    send_request(KIND_SPARE_LO,  16'hFFFF, 16'hFFFF, 6'd63);
    send_request(KIND_SPARE_HI,  16'h0000, 16'h0000, 6'd0);
    // Remove-by-tag that empties the queue
    send_request(KIND_OFFER,     16'd9,    16'h7777, 6'd0);
    send_request(KIND_OFFER,     16'd9,    16'h7777, 6'd0);
    send_request(KIND_REMTAG,    16'h0000, 16'h7777, 6'd0);
    // Equal keys keep arrival order; key extremes at both ends
    send_request(KIND_OFFER,     16'd100,  16'h0001, 6'd0);
    send_request(KIND_OFFER,     16'd100,  16'h0002, 6'd0);
    send_request(KIND_OFFER,     16'h0000, 16'h0003, 6'd0);
    send_request(KIND_OFFER,     16'hFFFF, 16'hFFFF, 6'd0);
    send_request(KIND_OFFER,     16'd100,  16'h0001, 6'd0);
    send_request(KIND_READ,      16'h0000, 16'h0000, 6'd3);
    send_request(KIND_READ,      16'h0000, 16'h0000, 6'd63);
    send_request(KIND_REMTAG,    16'h0000, 16'h0001, 6'd0);
    send_request(KIND_REMAT,     16'h0000, 16'h0000, 6'd1);
    send_request(KIND_REMAT,     16'h0000, 16'h0000, 6'd5);
    // Flip the order with entries held; they stay where they are
    wait_drained();
    write_order(1'b1);
    send_request(KIND_OFFER,     16'd50,   16'hAAAA, 6'd0);
    send_request(KIND_OFFER,     16'hFFFF, 16'h5555, 6'd0);
    send_request(KIND_OFFER,     16'h0000, 16'h0000, 6'd0);
    send_request(KIND_POLL,      16'h0000, 16'h0000, 6'd0);
    send_request(KIND_REMTAG,    16'h0000, 16'h0003, 6'd0);
    send_request(KIND_SPARE_MID, 16'h0000, 16'h0000, 6'd0);
    wait_drained();
    write_order(1'b0);

    // Random phases: fill, mixed and drain biases under each idling pattern
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      case (phase % 3)
        0:       offer_pct = 75;
        1:       offer_pct = 50;
        default: offer_pct = 20;
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long hold-off while requests keep coming, so the input backs up
        if (phase == 1 && n == 8)
          hold_seq = hold_seq + 1;
        send_random(offer_pct);
      end
      wait_drained();
      // alternate the order every three phases, entries left in place
      write_order(((phase + 1) / 3) % 2 == 1);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/sspq_pkg.sv
sv/sspq_ram.sv
sv/stable_sorted_priority_queue.sv
tb/sspq_checker.sv
tb/tb_top.sv
